@@ src/bfas_pkg.sv @@
`timescale 1ns / 1ps

package bfas_pkg;

    localparam int BLOOM_BITS  = 16384;
    localparam int HASH_COUNT  = 4;
    localparam int IDX_W       = $clog2(BLOOM_BITS);
    localparam int LANE_W      = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

    localparam int ADDR_BYTES  = 20;
    localparam int ADDR_BITS   = 8 * ADDR_BYTES;
    localparam int BYTE_CNT_W  = $clog2(ADDR_BYTES);

    localparam int ROW_W       = 32;
    localparam int COL_W       = $clog2(ROW_W);
    localparam int ROWS        = BLOOM_BITS / ROW_W;
    localparam int ROW_AW      = IDX_W - COL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [31:0] SEL_MUL   = 32'h9e3779b9;
    localparam logic [31:0] SEL_STEP  = 32'h1f4a8c1d;

    typedef enum logic [1:0] {
        K_ADDR  = 2'd0,
        K_SEL   = 2'd1,
        K_QUERY = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_RESULT
    } t_back_state;

    typedef struct packed {
        t_kind                            kind;
        logic                             has_sel;
        logic [HASH_COUNT-1:0][IDX_W-1:0] addr_idx;
        logic [HASH_COUNT-1:0][IDX_W-1:0] sel_idx;
    } t_job;

    // h * FNV_PRIME mod 2^32, prime is 2^24 + 2^8 + 2^7 + 2^4 + 2 + 1
    function automatic logic [31:0] fnv_mul(input logic [31:0] h);
        return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

    function automatic logic [31:0] sel_offset(input int unsigned lane);
        logic [63:0] p;
        p = 64'(lane) * 64'(SEL_STEP);
        return p[31:0];
    endfunction

endpackage

@@ src/bfas_ifs.sv @@
`timescale 1ns / 1ps

interface bfas_req_if;
    import bfas_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [31:0] addr_head;
    logic [63:0] addr_middle;
    logic [63:0] addr_tail;
    logic [31:0] selector_word;
    logic        has_selector;

    modport source (output valid, kind, addr_head, addr_middle, addr_tail,
                    selector_word, has_selector, input ready);
    modport sink   (input valid, kind, addr_head, addr_middle, addr_tail,
                    selector_word, has_selector, output ready);
endinterface

interface bfas_rsp_if;
    logic valid;
    logic ready;
    logic might_match;

    modport source (output valid, might_match, input ready);
    modport sink   (input valid, might_match, output ready);
endinterface

interface bfas_job_if;
    import bfas_pkg::*;
    logic valid;
    logic ready;
    t_job data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ src/bfas_front.sv @@
`timescale 1ns / 1ps

module bfas_front
    import bfas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clearing,
    bfas_req_if.sink          i_req,
    bfas_job_if.source        o_job
);

    t_front_state                 r_state, n_state;
    logic [BYTE_CNT_W-1:0]        r_cnt, n_cnt;
    logic [ADDR_BITS-1:0]         r_addr;
    t_kind                        r_kind;
    logic                         r_has_sel;
    logic [31:0]                  r_sel_prod;
    logic [HASH_COUNT-1:0][31:0]  r_h;
    logic [HASH_COUNT-1:0][31:0]  sel_h;
    logic                         accept;

    assign i_req.ready = (r_state == F_IDLE) && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // payload: address shifts out one byte per round, all chains step together
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= {i_req.addr_head, i_req.addr_middle, i_req.addr_tail};
            r_kind     <= i_req.kind;
            r_has_sel  <= i_req.has_selector;
            r_sel_prod <= i_req.selector_word * SEL_MUL;
            for (int l = 0; l < HASH_COUNT; l++) begin
                r_h[l] <= FNV_BASIS;
            end
        end else if (r_state == F_HASH) begin
            r_addr <= r_addr << 8;
            for (int l = 0; l < HASH_COUNT; l++) begin
                r_h[l] <= fnv_mul(r_h[l] ^ {24'd0, r_addr[ADDR_BITS-1 -: 8]}) ^ 32'(l);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_HASH;
                    n_cnt   = '0;
                end
            end
            F_HASH: begin
                if (r_cnt == BYTE_CNT_W'(ADDR_BYTES - 1)) begin
                    n_state = F_PUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            F_PUSH: begin
                if (o_job.ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_job.valid        = (r_state == F_PUSH);
        o_job.data.kind    = r_kind;
        o_job.data.has_sel = r_has_sel;
        for (int l = 0; l < HASH_COUNT; l++) begin
            sel_h[l]               = r_sel_prod ^ sel_offset(l);
            o_job.data.addr_idx[l] = r_h[l][IDX_W-1:0];
            o_job.data.sel_idx[l]  = sel_h[l][IDX_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == F_HASH) && (r_cnt == '0))
        else $error("front did not start hashing after a request");
`endif

endmodule

@@ src/bfas_queue.sv @@
`timescale 1ns / 1ps

module bfas_queue
    import bfas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfas_job_if.sink    i_job,
    bfas_job_if.source  o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign i_job.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_job.valid = (r_count != '0);
    assign o_job.data  = r_mem[r_rd_ptr];
    assign push        = i_job.valid && i_job.ready;
    assign pop         = o_job.valid && o_job.ready;

    function automatic logic [QA_W-1:0] ptr_next(input logic [QA_W-1:0] p);
        return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= QCNT_W'(QUEUE_DEPTH)) &&
        ((r_count == '0) || (r_count == QCNT_W'(QUEUE_DEPTH)) || (r_wr_ptr != r_rd_ptr)))
        else $error("queue count and pointers disagree");
`endif

endmodule

@@ src/bfas_back.sv @@
`timescale 1ns / 1ps

module bfas_back
    import bfas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    output logic        o_clearing,
    bfas_job_if.sink    i_job,
    bfas_rsp_if.source  o_rsp
);

    logic [ROW_W-1:0]  r_mem [ROWS];
    logic [ROW_W-1:0]  r_rd_data;

    t_back_state       r_state, n_state;
    t_job              r_job, n_job;
    logic [LANE_W-1:0] r_lane, n_lane;
    logic              r_phase, n_phase;
    logic              r_ok, n_ok;
    logic [ROW_AW-1:0] r_clr, n_clr;

    logic [IDX_W-1:0]  cur_idx;
    logic [ROW_AW-1:0] rd_row;
    logic [COL_W-1:0]  col;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_wa;
    logic [ROW_W-1:0]  mem_wd;
    logic              last_lane;

    // phase 0 walks the address bits, phase 1 the selector bits
    assign cur_idx    = r_phase ? r_job.sel_idx[r_lane] : r_job.addr_idx[r_lane];
    assign rd_row     = cur_idx[IDX_W-1:COL_W];
    assign col        = cur_idx[COL_W-1:0];
    assign last_lane  = (r_lane == LANE_W'(HASH_COUNT - 1));
    assign o_clearing = (r_state == B_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_lane  <= n_lane;
        r_phase <= n_phase;
        r_ok    <= n_ok;
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_lane      = r_lane;
        n_phase     = r_phase;
        n_ok        = r_ok;
        n_clr       = r_clr;
        mem_we      = 1'b0;
        mem_wa      = rd_row;
        mem_wd      = r_rd_data | (ROW_W'(1) << col);
        i_job.ready = 1'b0;
        o_rsp.valid = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == ROW_AW'(ROWS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                i_job.ready = 1'b1;
                if (i_job.valid) begin
                    n_job  = i_job.data;
                    n_lane = '0;
                    n_ok   = 1'b1;
                    unique case (i_job.data.kind)
                        K_ADDR: begin
                            n_phase = 1'b0;
                            n_state = B_READ;
                        end
                        K_SEL: begin
                            n_phase = 1'b1;
                            n_state = B_READ;
                        end
                        K_QUERY: begin
                            n_phase = 1'b0;
                            n_state = B_READ;
                        end
                        K_NONE: begin
                            n_phase = 1'b0;
                            n_state = B_RESULT;
                        end
                    endcase
                end
            end
            B_READ: begin
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (r_job.kind == K_QUERY) begin
                    n_ok = r_ok & r_rd_data[col];
                end else begin
                    mem_we = 1'b1;
                end
                if (!last_lane) begin
                    n_lane  = r_lane + 1'b1;
                    n_state = B_READ;
                end else if (!r_phase && r_job.kind == K_QUERY && r_job.has_sel) begin
                    n_lane  = '0;
                    n_phase = 1'b1;
                    n_state = B_READ;
                end else begin
                    n_state = B_RESULT;
                end
            end
            B_RESULT: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_rsp.might_match = r_ok && (r_job.kind == K_QUERY);

`ifndef SYNTHESIS
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHECK && r_job.kind == K_QUERY) |-> !mem_we)
        else $error("query wrote the filter array");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.valid && i_job.ready) |=> (r_state == B_READ || r_state == B_RESULT))
        else $error("popped request did not start");

    a_rsp_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> (r_state == B_IDLE))
        else $error("back did not return to idle after a result");
`endif

endmodule

@@ src/bloom_filter_address_selector_core.sv @@
// from acceptance to result: the front hashes the address one byte per round and pushes
//   the job into the queue; the back pops it, reads and sets or checks each filter bit
//   (4 accesses for an insert, 4 or 8 for a query, none for the unused kind), then answers
// the front takes a new request only once it has hashed the last one and handed it on
// reset: synchronous, active low; afterwards a clearing pass writes the 512 rows of the
//   filter array and no request is taken until it ends
`timescale 1ns / 1ps

module bloom_filter_address_selector_core
    import bfas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfas_req_if.sink   i_req,
    bfas_rsp_if.source o_rsp
);

    bfas_job_if job_fq ();
    bfas_job_if job_qb ();
    logic       clearing;

    bfas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_req      (i_req),
        .o_job      (job_fq.source)
    );

    bfas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_fq.sink),
        .o_job   (job_qb.source)
    );

    bfas_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_job      (job_qb.sink),
        .o_rsp      (o_rsp)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bfas_pkg::*;

    localparam int N_RANDOM  = 1900;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] head;
        logic [63:0] middle;
        logic [63:0] tail;
        logic [31:0] sel;
        logic        has_sel;
    } bf_req_t;

    // shadow copy of the filter array, predicts one answer per request
    class bloom_shadow;
        bit filter [BLOOM_BITS];
        bit answers_due [$];
        int errors;
        int n_checked;
        int n_hits;
        int n_kind [4];

        function bit [31:0] addr_hash(bit [ADDR_BITS-1:0] addr, bit [31:0] lane);
            bit [31:0] h;
            h = FNV_BASIS;
            for (int k = 0; k < ADDR_BYTES; k++) begin
                h = h ^ {24'd0, addr[ADDR_BITS-1-8*k -: 8]};
                h = h * FNV_PRIME;
                h = h ^ lane;
            end
            return h;
        endfunction

        function bit [31:0] sel_hash(bit [31:0] sel, bit [31:0] lane);
            return (sel * SEL_MUL) ^ (lane * SEL_STEP);
        endfunction

        function void record_request(bf_req_t r);
            bit [ADDR_BITS-1:0] addr;
            bit [31:0]          h;
            bit                 hit;
            addr = {r.head, r.middle, r.tail};
            hit  = 1'b0;
            n_kind[int'(r.kind)]++;
            case (r.kind)
                K_ADDR: begin
                    for (int i = 0; i < HASH_COUNT; i++) begin
                        h = addr_hash(addr, i);
                        filter[h[IDX_W-1:0]] = 1'b1;
                    end
                end
                K_SEL: begin
                    for (int i = 0; i < HASH_COUNT; i++) begin
                        h = sel_hash(r.sel, i);
                        filter[h[IDX_W-1:0]] = 1'b1;
                    end
                end
                K_QUERY: begin
                    hit = 1'b1;
                    for (int i = 0; i < HASH_COUNT; i++) begin
                        h = addr_hash(addr, i);
                        if (!filter[h[IDX_W-1:0]]) hit = 1'b0;
                    end
                    // selector bits only matter once the address passed
                    if (hit && r.has_sel) begin
                        for (int i = 0; i < HASH_COUNT; i++) begin
                            h = sel_hash(r.sel, i);
                            if (!filter[h[IDX_W-1:0]]) hit = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (hit) n_hits++;
            answers_due.push_back(hit);
        endfunction

        function void check_answer(logic got);
            bit want;
            if (answers_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: answer %b arrived with no request pending", $realtime, got);
                return;
            end
            want = answers_due.pop_front();
            n_checked++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: answer %0d: might_match expected %b, got %b",
                             $realtime, n_checked, want, got);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bfas_req_if req_if ();
    bfas_rsp_if rsp_if ();

    bloom_shadow        shadow = new();
    bit [ADDR_BITS-1:0] addr_pool [$];
    bit [31:0]          sel_pool [$];

    bloom_filter_address_selector_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    function automatic bf_req_t make_req(t_kind kind, bit [ADDR_BITS-1:0] addr,
                                         bit [31:0] sel, bit has_sel);
        bf_req_t r;
        r.kind    = kind;
        r.head    = addr[159:128];
        r.middle  = addr[127:64];
        r.tail    = addr[63:0];
        r.sel     = sel;
        r.has_sel = has_sel;
        return r;
    endfunction

    // mostly random words, sometimes the all-zero and all-one corners
    function automatic bit [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [ADDR_BITS-1:0] pick_addr();
        return {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    // inserts feed the pools so most queries look up something already stored
    function automatic bf_req_t random_req();
        bit [ADDR_BITS-1:0] addr;
        bit [31:0]          sel;
        int                 pick;
        pick = $urandom_range(0, 99);
        addr = pick_addr();
        sel  = pick_word();
        if (pick < 28) begin
            addr_pool.push_back(addr);
            return make_req(K_ADDR, addr, sel, 1'($urandom_range(0, 1)));
        end
        if (pick < 42) begin
            sel_pool.push_back(sel);
            return make_req(K_SEL, addr, sel, 1'($urandom_range(0, 1)));
        end
        if (pick < 94) begin
            if (addr_pool.size() > 0 && $urandom_range(0, 3) != 0)
                addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            if (sel_pool.size() > 0 && $urandom_range(0, 9) < 7)
                sel = sel_pool[$urandom_range(0, sel_pool.size() - 1)];
            return make_req(K_QUERY, addr, sel, 1'($urandom_range(0, 1)));
        end
        return make_req(K_NONE, addr, sel, 1'($urandom_range(0, 1)));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(bf_req_t r);
        req_if.valid         <= 1'b1;
        req_if.kind          <= r.kind;
        req_if.addr_head     <= r.head;
        req_if.addr_middle   <= r.middle;
        req_if.addr_tail     <= r.tail;
        req_if.selector_word <= r.sel;
        req_if.has_selector  <= r.has_sel;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        shadow.record_request(r);
        @(negedge clk);
    endtask

    task automatic idle_for(int cycles);
        req_if.valid         <= 1'b0;
        req_if.kind          <= t_kind'($urandom_range(0, 3));
        req_if.addr_head     <= $urandom;
        req_if.addr_middle   <= {$urandom, $urandom};
        req_if.addr_tail     <= {$urandom, $urandom};
        req_if.selector_word <= $urandom;
        req_if.has_selector  <= 1'($urandom_range(0, 1));
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge clk); while (shadow.pending() != 0);
    endtask

    // response side: switches between always ready, coin flips and long stalls
    initial begin
        int cyc;
        int mode;
        int stall_left;
        cyc        = 0;
        mode       = 0;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0) mode = $urandom_range(0, 2);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(4, 40);
                            rsp_if.ready <= 1'b0;
                        end else begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            shadow.check_answer(rsp_if.might_match);
    end

    initial begin
        bit [ADDR_BITS-1:0] zeros;
        bit [ADDR_BITS-1:0] ones;
        bit [ADDR_BITS-1:0] top_bit;
        bit [ADDR_BITS-1:0] low_bit;
        int                 sent;
        int                 burst;
        zeros   = '0;
        ones    = '1;
        top_bit = {1'b1, {(ADDR_BITS-1){1'b0}}};
        low_bit = {{(ADDR_BITS-1){1'b0}}, 1'b1};

        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = K_ADDR;
        req_if.addr_head     = '0;
        req_if.addr_middle   = '0;
        req_if.addr_tail     = '0;
        req_if.selector_word = '0;
        req_if.has_selector  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty filter, then corner addresses and selectors
        send_req(make_req(K_QUERY, zeros, 32'h0, 1'b0));
        send_req(make_req(K_QUERY, ones, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_NONE, ones, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_ADDR, zeros, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_QUERY, zeros, 32'hffff_ffff, 1'b0));
        send_req(make_req(K_QUERY, zeros, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_SEL, ones, 32'h0, 1'b1));
        send_req(make_req(K_QUERY, zeros, 32'h0, 1'b1));
        send_req(make_req(K_QUERY, ones, 32'h0, 1'b1));
        send_req(make_req(K_ADDR, ones, 32'h0, 1'b0));
        send_req(make_req(K_SEL, zeros, 32'hffff_ffff, 1'b0));
        send_req(make_req(K_QUERY, ones, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_QUERY, ones, 32'hffff_ffff, 1'b0));
        send_req(make_req(K_NONE, zeros, 32'h0, 1'b0));
        send_req(make_req(K_QUERY, zeros, 32'hffff_ffff, 1'b1));
        send_req(make_req(K_ADDR, top_bit, 32'h8000_0000, 1'b1));
        send_req(make_req(K_QUERY, top_bit, 32'h8000_0000, 1'b1));
        send_req(make_req(K_QUERY, low_bit, 32'h8000_0000, 1'b0));
        send_req(make_req(K_SEL, low_bit, 32'h8000_0000, 1'b0));
        send_req(make_req(K_QUERY, top_bit, 32'h8000_0000, 1'b1));
        send_req(make_req(K_QUERY, zeros, 32'h0000_0001, 1'b1));
        drain();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                send_req(random_req());
                sent++;
                if (sent % 500 == 0) drain();
            end
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 30));
        end

        drain();
        repeat (60) @(posedge clk);

        $display("%0d answers checked: %0d address inserts, %0d selector inserts,",
                 shadow.n_checked, shadow.n_kind[K_ADDR], shadow.n_kind[K_SEL]);
        $display("%0d queries with %0d hits, %0d unused-kind requests, %0d mismatches",
                 shadow.n_kind[K_QUERY], shadow.n_hits, shadow.n_kind[K_NONE],
                 shadow.errors);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d answers outstanding", shadow.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ bloom_filter_address_selector_core.f @@
src/bfas_pkg.sv
src/bfas_ifs.sv
src/bfas_front.sv
src/bfas_queue.sv
src/bfas_back.sv
src/bloom_filter_address_selector_core.sv
tb/tb_top.sv
